// ----- rtl/fba_pkg.sv -----
// ----------------------------------------------------------------------------
// fba_pkg: shared definitions for the fit block allocator
// Field widths, register indexes, item kinds, sequencer states and the
// table write request passed between the top level and the size table.
// ----------------------------------------------------------------------------
package fba_pkg;

	// default table geometry
	localparam int NUM_BLOCKS_DEF = 16;
	localparam int SIZE_BITS_DEF  = 16;

	// upper bounds of the geometry, used to size the write request
	localparam int TBL_ADDR_MAX = 8;
	localparam int TBL_DATA_MAX = 32;

	// fixed field widths of the stream items
	localparam int IDX_W  = 4;
	localparam int VAL_W  = 16;
	localparam int CNT_W  = 5;
	localparam int S_DATA_W = 24;
	localparam int M_DATA_W = 40;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'b1;

	// register reset values and codes
	localparam logic             FIT_FIRST   = 1'b0;
	localparam logic             FIT_BEST    = 1'b1;
	localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

	// item kinds
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_ALLOC = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} fba_state_t;

	// table write request
	typedef struct packed {
		logic                    en;
		logic [TBL_ADDR_MAX-1:0] addr;
		logic [TBL_DATA_MAX-1:0] data;
	} fba_wr_t;

endpackage

// ----- rtl/fba_table.sv -----
// ----------------------------------------------------------------------------
// fba_table: remaining size table
// One write port and one registered read port. A valid bit per entry,
// cleared by reset, makes an entry read as zero until it is first written.
// ----------------------------------------------------------------------------
module fba_table #(
	parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF,
	localparam int ADDR_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output logic [SIZE_BITS-1:0] rd_data,
	input  fba_pkg::fba_wr_t     wr
);
	import fba_pkg::*;

	logic [SIZE_BITS-1:0] mem [NUM_BLOCKS];
	logic [NUM_BLOCKS-1:0] valid_q;
	logic [SIZE_BITS-1:0] rd_mem_q;
	logic                 rd_vld_q;
	logic [ADDR_BITS-1:0] wr_addr;

	assign wr_addr = wr.addr[ADDR_BITS-1:0];

	// storage write and registered read
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data[SIZE_BITS-1:0];
		end
		rd_mem_q <= mem[rd_addr];
	end

	// valid bits, cleared at once by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr.en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= valid_q[rd_addr];
		end
	end

	// an entry never written reads as zero
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

// ----- rtl/fit_block_allocator_top.sv -----
// An allocation item is accepted, then scans min(block_count, NUM_BLOCKS) entries
// on the single table read port and shared compare, drains the read register, and
// writes back and registers the result once the output register is free. A load
// item is accepted and then written back. The result is registered; the next item
// is taken while it waits. Reset clears table valid bits and control registers at once.
// ----------------------------------------------------------------------------
// fit_block_allocator_top: first fit / best fit block allocator
// Load items write one remaining size when the index is in range; allocate items scan
// the table one entry a cycle through one compare unit and shrink the chosen block.
// ----------------------------------------------------------------------------
module fit_block_allocator_top #(
	parameter int NUM_BLOCKS = fba_pkg::NUM_BLOCKS_DEF,
	parameter int SIZE_BITS  = fba_pkg::SIZE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write port
	input  logic                          cfg_we,
	input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_wdata,
	// input items
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [fba_pkg::S_DATA_W-1:0]  s_tdata,  // block_index, size_value
	input  logic [0:0]                    s_tuser,  // req_type
	// result items
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [fba_pkg::M_DATA_W-1:0]  m_tdata,  // chosen_index, unplaced_size, room_left
	output logic [0:0]                    m_tuser   // granted
);
	import fba_pkg::*;

	localparam int ADDR_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int SCAN_BITS = $clog2(NUM_BLOCKS + 1);

	fba_state_t state_q, state_d;

	// configuration
	logic             cfg_mode_q;
	logic [CNT_W-1:0] cfg_count_q;

	// item being worked on
	logic                 kind_q;
	logic                 mode_q;
	logic [IDX_W-1:0]     idx_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [SCAN_BITS-1:0] limit_q;
	logic [SCAN_BITS-1:0] scan_q;

	// search pipeline and best candidate
	logic                 issue_s1;
	logic [ADDR_BITS-1:0] idx_s1;
	logic                 found_q;
	logic [ADDR_BITS-1:0] pick_q;
	logic [SIZE_BITS-1:0] best_q;

	// output register
	logic                 out_vld_q;
	logic                 out_grant_q;
	logic [IDX_W-1:0]     out_idx_q;
	logic [VAL_W-1:0]     out_unpl_q;
	logic [VAL_W-1:0]     out_room_q;

	logic                 accept;
	logic                 out_free;
	logic                 out_load;
	logic                 rd_issue;
	logic                 idx_in_range;
	logic [SIZE_BITS-1:0] rd_data;
	logic [SIZE_BITS-1:0] shrunk;
	logic [SIZE_BITS-1:0] in_size;
	logic [SCAN_BITS-1:0] in_limit;
	logic                 fits;
	logic                 take;
	fba_wr_t              tbl_wr;
	logic                 res_grant;
	logic [IDX_W-1:0]     res_idx;
	logic [VAL_W-1:0]     res_unpl;
	logic [VAL_W-1:0]     res_room;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	// input field decode
	assign in_size  = SIZE_BITS'(s_tdata[19:4]);
	assign in_limit = (32'(cfg_count_q) > NUM_BLOCKS) ? SCAN_BITS'(NUM_BLOCKS)
	                                                  : SCAN_BITS'(cfg_count_q);
	assign idx_in_range = (32'(idx_q) < NUM_BLOCKS);

	// shared compare unit
	assign fits   = (rd_data >= req_q);
	assign take   = issue_s1 && fits &&
	                (!found_q || ((mode_q == FIT_BEST) && (rd_data < best_q)));
	assign shrunk = best_q - req_q;

	// result of the current item
	always_comb begin
		res_grant = 1'b0;
		res_idx   = '0;
		res_unpl  = '0;
		res_room  = '0;
		if (kind_q == REQ_LOAD) begin
			res_idx  = idx_q;
			res_room = idx_in_range ? VAL_W'(req_q) : '0;
		end else if (found_q) begin
			res_grant = 1'b1;
			res_idx   = IDX_W'(pick_q);
			res_room  = VAL_W'(shrunk);
		end else begin
			res_unpl  = VAL_W'(req_q);
		end
	end

	// sequencer: next state, table write, output load
	always_comb begin
		state_d  = state_q;
		rd_issue = 1'b0;
		out_load = 1'b0;
		tbl_wr   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = (s_tuser[0] == REQ_ALLOC) ? ST_SCAN : ST_WRITE;
				end
			end
			ST_SCAN: begin
				rd_issue = (scan_q < limit_q);
				// the last compare registers its candidate on the leaving edge
				if (!rd_issue) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (kind_q == REQ_LOAD) begin
						tbl_wr.en   = idx_in_range;
						tbl_wr.addr = TBL_ADDR_MAX'(idx_q);
						tbl_wr.data = TBL_DATA_MAX'(req_q);
					end else begin
						tbl_wr.en   = found_q;
						tbl_wr.addr = TBL_ADDR_MAX'(pick_q);
						tbl_wr.data = TBL_DATA_MAX'(shrunk);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode_q  <= FIT_BEST;
			cfg_count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIT_MODE:    cfg_mode_q  <= cfg_wdata[0];
				REG_BLOCK_COUNT: cfg_count_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// control state of the search and the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1  <= 1'b0;
			found_q   <= 1'b0;
			scan_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			issue_s1 <= rd_issue;
			if (accept) begin
				found_q <= 1'b0;
				scan_q  <= '0;
			end else begin
				if (rd_issue) begin
					scan_q <= scan_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// item payload, candidate and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= s_tuser[0];
			mode_q  <= cfg_mode_q;
			idx_q   <= s_tdata[3:0];
			req_q   <= in_size;
			limit_q <= in_limit;
		end
		idx_s1 <= scan_q[ADDR_BITS-1:0];
		if (take) begin
			pick_q <= idx_s1;
			best_q <= rd_data;
		end
		if (out_load) begin
			out_grant_q <= res_grant;
			out_idx_q   <= res_idx;
			out_unpl_q  <= res_unpl;
			out_room_q  <= res_room;
		end
	end

	// size table
	fba_table #(
		.NUM_BLOCKS(NUM_BLOCKS),
		.SIZE_BITS (SIZE_BITS)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_addr(scan_q[ADDR_BITS-1:0]),
		.rd_data(rd_data),
		.wr     (tbl_wr)
	);

	// result port
	assign m_tvalid   = out_vld_q;
	assign m_tuser[0] = out_grant_q;
	assign m_tdata    = {4'b0000, out_room_q, out_unpl_q, out_idx_q};

`ifndef SYNTHESIS
	// an accepted item keeps the block busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("block ready straight after accepting an item");

	// the scan never runs past the searched range
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= limit_q))
		else $error("scan index beyond search limit");

	// a granted result never reports an unplaced amount
	a_grant_unplaced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_grant_q) |-> (out_unpl_q == '0))
		else $error("granted result with unplaced size");

	// a table write only happens when the result is loaded
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr.en |-> (out_load && (state_q == ST_WRITE)))
		else $error("table written outside write-back");
`endif

endmodule
